FILE: rtl/core/parb_pkg.sv
// shared constants, types and controller states of the proximity brightness block
package parb_pkg;

  localparam int HORIZ_CHANNELS  = 7;
  localparam int GROUND_CHANNELS = 2;
  localparam int TOTAL_CHANNELS  = HORIZ_CHANNELS + GROUND_CHANNELS;

  localparam int CH_W     = 4;
  localparam int SAMPLE_W = 16;
  localparam int LED_W    = 4;
  localparam int FS_W     = 8;
  localparam int PROD_W   = SAMPLE_W + FS_W;
  localparam int BRIGHT_W = FS_W;

  localparam int PEAK_IDX_W  = (TOTAL_CHANNELS > 1) ? $clog2(TOTAL_CHANNELS) : 1;
  localparam int FLOOR_IDX_W = (HORIZ_CHANNELS > 1) ? $clog2(HORIZ_CHANNELS) : 1;
  localparam int DIV_CNT_W   = $clog2(BRIGHT_W);

  localparam logic [SAMPLE_W-1:0] HORIZ_PEAK_RESET  = SAMPLE_W'(4000);
  localparam logic [SAMPLE_W-1:0] HORIZ_FLOOR_RESET = SAMPLE_W'(1200);
  localparam logic [SAMPLE_W-1:0] GROUND_PEAK_RESET = SAMPLE_W'(900);
  localparam logic [FS_W-1:0]     FULL_SCALE_RESET  = FS_W'(32);
  localparam logic [CH_W-1:0]     DOUBLED_CHANNEL   = CH_W'(2);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = CFG_IDX_W'(1);
  localparam int CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } parb_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic mul;
    logic div_init;
    logic div_step;
    logic load_out;
  } parb_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic div_last;
    logic out_free;
  } parb_sts_t;

endpackage

FILE: rtl/core/parb_in_if.sv
// input sample channel
interface parb_in_if import parb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

FILE: rtl/core/parb_out_if.sv
// brightness result channel
interface parb_out_if import parb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [LED_W-1:0]    led_index;
  logic                also_next;
  logic [BRIGHT_W-1:0] brightness;

  modport source (output valid, output led_index, output also_next, output brightness,
                  input ready);
  modport sink   (input valid, input led_index, input also_next, input brightness,
                  output ready);
endinterface

FILE: rtl/core/parb_cfg_if.sv
// configuration write channel
interface parb_cfg_if import parb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/parb_ctrl.sv
// sequencing state machine for one sample
module parb_ctrl import parb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  parb_sts_t sts,
  output logic      in_ready,
  output parb_cmd_t cmd
);

  parb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        // disabled or unknown channel: the transfer is simply dropped
        if (in_valid && sts.in_ok) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/parb_dp.sv
// tracking registers, scaling multiplier, radix-2 divider and result register
module parb_dp import parb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  parb_cmd_t             cmd,
  output parb_sts_t             sts,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LED_W-1:0]      out_led_index,
  output logic                  out_also_next,
  output logic [BRIGHT_W-1:0]   out_brightness
);

  logic                enable_r;
  logic [FS_W-1:0]     full_scale_r;
  logic [SAMPLE_W-1:0] peak_r  [TOTAL_CHANNELS];
  logic [SAMPLE_W-1:0] floor_r [HORIZ_CHANNELS];

  logic [CH_W-1:0]      ch_r;
  logic [SAMPLE_W-1:0]  smp_r;
  logic [SAMPLE_W-1:0]  num_r, den_r;
  logic [PROD_W-1:0]    prod_r;
  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [BRIGHT_W-1:0]  low_r, quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 zero_r;
  logic                 out_valid_r;
  logic [LED_W-1:0]     led_r;
  logic                 next_r;
  logic [BRIGHT_W-1:0]  bright_r;

  logic                   is_horiz;
  logic [PEAK_IDX_W-1:0]  pidx;
  logic [FLOOR_IDX_W-1:0] fidx;
  logic [SAMPLE_W-1:0]    pk_old, pk_new, fl_old, fl_new, num_nxt, den_nxt;
  logic [SAMPLE_W:0]      trial;
  logic                   qbit;

  assign is_horiz = ch_r < CH_W'(HORIZ_CHANNELS);
  assign pidx     = ch_r[PEAK_IDX_W-1:0];
  assign fidx     = ch_r[FLOOR_IDX_W-1:0];

  // tracking follows the new sample before scaling
  always_comb begin
    pk_old = peak_r[pidx];
    pk_new = (smp_r > pk_old) ? smp_r : pk_old;
    fl_old = is_horiz ? floor_r[fidx] : '0;
    fl_new = ((smp_r != '0) && (smp_r < fl_old)) ? smp_r : fl_old;
    if (is_horiz) begin
      num_nxt = (smp_r > fl_new) ? smp_r - fl_new : '0;
      den_nxt = (pk_new > fl_new) ? pk_new - fl_new : '0;
    end else begin
      num_nxt = smp_r;
      den_nxt = pk_new;
    end
  end

  // quotient never exceeds full scale, so the top bits of the product start below the divisor
  assign trial   = {rem_r, low_r[BRIGHT_W-1]};
  assign qbit    = trial >= {1'b0, den_r};
  assign rem_nxt = qbit ? SAMPLE_W'(trial - {1'b0, den_r}) : trial[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      full_scale_r <= FULL_SCALE_RESET;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < TOTAL_CHANNELS; i++) begin
        peak_r[i] <= (i < HORIZ_CHANNELS) ? HORIZ_PEAK_RESET : GROUND_PEAK_RESET;
      end
      for (int i = 0; i < HORIZ_CHANNELS; i++) begin
        floor_r[i] <= HORIZ_FLOOR_RESET;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     enable_r     <= cfg_data[0];
          CFG_FULL_SCALE: full_scale_r <= cfg_data[FS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        peak_r[pidx] <= pk_new;
        if (is_horiz) begin
          floor_r[fidx] <= fl_new;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r  <= in_channel;
      smp_r <= in_sample;
    end
    if (cmd.update) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(num_r) * PROD_W'(full_scale_r);
    end
    if (cmd.div_init) begin
      rem_r  <= prod_r[PROD_W-1:BRIGHT_W];
      low_r  <= prod_r[BRIGHT_W-1:0];
      quo_r  <= '0;
      cnt_r  <= '0;
      zero_r <= den_r == '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[BRIGHT_W-2:0], 1'b0};
      quo_r <= {quo_r[BRIGHT_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.load_out) begin
      led_r    <= (ch_r > DOUBLED_CHANNEL) ? LED_W'(ch_r + 1'b1) : LED_W'(ch_r);
      next_r   <= ch_r == DOUBLED_CHANNEL;
      bright_r <= zero_r ? '0 : quo_r;
    end
  end

  assign sts.in_ok    = enable_r && (in_channel < CH_W'(TOTAL_CHANNELS));
  assign sts.div_last = cnt_r == DIV_CNT_W'(BRIGHT_W - 1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_led_index  = led_r;
  assign out_also_next  = next_r;
  assign out_brightness = bright_r;

endmodule

FILE: rtl/core/proximity_auto_range_brightness_unit.sv
// Automatic indicator brightness from proximity samples by min/max auto-ranging.
// Each transfer on in_ch carries a channel (0 to 6 horizontal, 7 and 8 ground) and a
// 16-bit reading; the block updates that channel's tracked peak (and floor, for
// horizontal channels, ignoring zero readings) and returns one transfer on out_ch with
// the indicator index, the also_next flag for horizontal channel 2, and brightness =
// span-relative reading * full_scale / span. A sample arriving while disabled, or on a
// channel above 8, is taken and dropped with no result and no tracking change. One item
// passes from transfer to result through these steps in order: tracking update, the
// 16x8 multiply, loading the divider, an 8-step restoring divider producing one
// quotient bit per cycle, and loading the output register. The next sample is taken
// in the cycle after the output load, once the result sits in the output register,
// even if it has not yet been collected; no new sample is taken while an item is in
// progress. A result left uncollected holds the following item before its output load
// and keeps the input stalled. Configuration writes (index 0 enable, 1 full_scale)
// are always ready and should be made only while the block is idle.
module proximity_auto_range_brightness_unit import parb_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  parb_in_if.sink    in_ch,
  parb_out_if.source out_ch,
  parb_cfg_if.sink   cfg_ch
);

  parb_cmd_t cmd;
  parb_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  parb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  parb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_channel     (in_ch.channel),
    .in_sample      (in_ch.sample),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_led_index  (out_ch.led_index),
    .out_also_next  (out_ch.also_next),
    .out_brightness (out_ch.brightness)
  );

endmodule
